// ===== rtl/ncdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared constants, control struct and arithmetic helpers for the normal CDF.
// ----------------------------------------------------------------------------
package ncdf_pkg;

  // Fixed-point constants (Q16 unless noted)
  localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;
  localparam logic [14:0] P_Q16         = 15'd21469;
  localparam logic [16:0] LOG2E_Q16     = 17'd94548;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [30:0] ONE_Q30       = 31'd1073741824;
  localparam logic [17:0] ONE_Q16       = 18'd65536;

  localparam logic signed [23:0] A1_Q16 = 24'sd16701;
  localparam logic signed [23:0] A2_Q16 = -24'sd18645;
  localparam logic signed [23:0] A3_Q16 = 24'sd93154;
  localparam logic signed [23:0] A4_Q16 = -24'sd95234;
  localparam logic signed [23:0] A5_Q16 = 24'sd69560;

  // Unit depths
  localparam int RECIP_STAGES  = 17;
  localparam int HORNER_STAGES = 5;
  localparam int EXP_TERMS     = 8;
  localparam int EXP_LATENCY   = 2 * EXP_TERMS + 3;
  localparam int E_DELAY       = RECIP_STAGES + HORNER_STAGES - EXP_LATENCY;

  typedef struct packed {
    logic vld;
    logic neg;
  } ncdf_ctl_t;

  // Q16 rounding, half away from zero
  function automatic logic signed [31:0] round_q16(input logic signed [47:0] v);
    logic signed [47:0] s;
    s = v + (v[47] ? 48'sd32767 : 48'sd32768);
    return 32'(s >>> 16);
  endfunction

  // Horner addend after stage j (last stage adds nothing)
  function automatic logic signed [23:0] horner_coef(input int j);
    logic signed [23:0] c;
    case (j)
      0:       c = A4_Q16;
      1:       c = A3_Q16;
      2:       c = A2_Q16;
      3:       c = A1_Q16;
      default: c = 24'sd0;
    endcase
    return c;
  endfunction

  // floor(n / i) for small constant i, reciprocal multiply for odd factors
  function automatic logic [30:0] div_const(input logic [30:0] n, input int i);
    logic [62:0] p;
    logic [30:0] q;
    p = 63'd0;
    case (i)
      3: begin
        p = 63'(n) * 63'(32'hAAAAAAAB);
        q = 31'(p >> 33);
      end
      5: begin
        p = 63'(n) * 63'(32'hCCCCCCCD);
        q = 31'(p >> 34);
      end
      6: begin
        p = 63'(n) * 63'(32'hAAAAAAAB);
        q = 31'(p >> 34);
      end
      7: begin
        p = 63'(n) * 63'(32'h92492493);
        q = 31'(p >> 34);
      end
      2:       q = n >> 1;
      4:       q = n >> 2;
      8:       q = n >> 3;
      default: q = n;
    endcase
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ncdf_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncdf_recip
// Pipelined restoring divider: t = (2^32 + d/2) / d, one quotient bit a stage.
// ----------------------------------------------------------------------------
module ncdf_recip (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ncdf_pkg::ncdf_ctl_t in_ctl,
  input  wire logic [17:0]        in_d,
  output ncdf_pkg::ncdf_ctl_t     out_ctl,
  output logic [16:0]             out_t
);
  import ncdf_pkg::*;

  ncdf_ctl_t   ctl_r [RECIP_STAGES];
  logic [17:0] rem_r [RECIP_STAGES];
  logic [17:0] d_r   [RECIP_STAGES];
  logic [16:0] q_r   [RECIP_STAGES];

  for (genvar j = 0; j < RECIP_STAGES; j++) begin : g_div
    localparam int B = RECIP_STAGES - 1 - j;  // quotient bit of this stage
    ncdf_ctl_t   ctl_i;
    logic [17:0] rem_i, d_i, rem_nxt;
    logic [16:0] q_i, q_nxt;
    logic [18:0] sh, diff;

    if (j == 0) begin : g_first
      // high part of the dividend is 2^15, already below d
      assign ctl_i = in_ctl;
      assign rem_i = 18'd32768;
      assign d_i   = in_d;
      assign q_i   = '0;
    end else begin : g_next
      assign ctl_i = ctl_r[j-1];
      assign rem_i = rem_r[j-1];
      assign d_i   = d_r[j-1];
      assign q_i   = q_r[j-1];
    end

    // low dividend bit B is bit B of d/2
    always_comb begin
      sh      = {rem_i, d_i[B+1]};
      diff    = sh - {1'b0, d_i};
      q_nxt   = q_i;
      rem_nxt = sh[17:0];
      if (sh >= {1'b0, d_i}) begin
        rem_nxt  = diff[17:0];
        q_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else begin
        ctl_r[j] <= ctl_i;
      end
      rem_r[j] <= rem_nxt;
      d_r[j]   <= d_i;
      q_r[j]   <= q_nxt;
    end
  end

  assign out_ctl = ctl_r[RECIP_STAGES-1];
  assign out_t   = q_r[RECIP_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/ncdf_horner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncdf_horner
// Fifth-order polynomial in t, one multiply-round-add per stage.
// ----------------------------------------------------------------------------
module ncdf_horner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ncdf_pkg::ncdf_ctl_t in_ctl,
  input  wire logic [16:0]         in_t,
  output ncdf_pkg::ncdf_ctl_t      out_ctl,
  output logic signed [23:0]       out_poly
);
  import ncdf_pkg::*;

  ncdf_ctl_t          ctl_r [HORNER_STAGES];
  logic [16:0]        t_r   [HORNER_STAGES];
  logic signed [23:0] acc_r [HORNER_STAGES];

  for (genvar j = 0; j < HORNER_STAGES; j++) begin : g_hrn
    ncdf_ctl_t          ctl_i;
    logic [16:0]        t_i;
    logic signed [23:0] acc_i, acc_nxt;
    logic signed [41:0] prod;
    logic signed [31:0] rnd;

    if (j == 0) begin : g_first
      assign ctl_i = in_ctl;
      assign t_i   = in_t;
      assign acc_i = A5_Q16;
    end else begin : g_next
      assign ctl_i = ctl_r[j-1];
      assign t_i   = t_r[j-1];
      assign acc_i = acc_r[j-1];
    end

    always_comb begin
      prod    = 42'(acc_i) * 42'($signed({1'b0, t_i}));
      rnd     = round_q16(48'(prod));
      acc_nxt = 24'(rnd + 32'(horner_coef(j)));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else begin
        ctl_r[j] <= ctl_i;
      end
      t_r[j]   <= t_i;
      acc_r[j] <= acc_nxt;
    end
  end

  assign out_ctl  = ctl_r[HORNER_STAGES-1];
  assign out_poly = acc_r[HORNER_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/ncdf_exp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncdf_exp
// exp(-w) in Q16: range reduction by log2(e), nested 8-term series, shift.
// ----------------------------------------------------------------------------
module ncdf_exp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [21:0] in_w,
  output logic             out_vld,
  output logic [16:0]      out_e
);
  import ncdf_pkg::*;

  // reduction stages
  logic        v0_r, v1_r;
  logic [5:0]  k0_r, k1_r;
  logic [15:0] f0_r;
  logic [29:0] r1_r;
  logic [38:0] u_full;
  logic [45:0] r_full;

  always_comb begin
    u_full = 39'(in_w) * 39'(LOG2E_Q16) + 39'd32768;
    r_full = 46'(f0_r) * 46'(LN2_Q30) + 46'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
    end
    k0_r <= u_full[37:32];
    f0_r <= u_full[31:16];
    k1_r <= k0_r;
    r1_r <= r_full[45:16];
  end

  // series: each term is a multiply stage then a divide-and-subtract stage
  logic        va_r   [EXP_TERMS];
  logic [60:0] prod_r [EXP_TERMS];
  logic [29:0] ra_r   [EXP_TERMS];
  logic [5:0]  ka_r   [EXP_TERMS];
  logic        vb_r   [EXP_TERMS];
  logic [30:0] acc_r  [EXP_TERMS];
  logic [29:0] rb_r   [EXP_TERMS];
  logic [5:0]  kb_r   [EXP_TERMS];

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int I = EXP_TERMS - j;
    logic        v_i;
    logic [30:0] acc_i;
    logic [29:0] r_i;
    logic [5:0]  k_i;
    logic [60:0] num;
    logic [30:0] n, q, acc_nxt;

    if (j == 0) begin : g_first
      assign v_i   = v1_r;
      assign acc_i = ONE_Q30;
      assign r_i   = r1_r;
      assign k_i   = k1_r;
    end else begin : g_next
      assign v_i   = vb_r[j-1];
      assign acc_i = acc_r[j-1];
      assign r_i   = rb_r[j-1];
      assign k_i   = kb_r[j-1];
    end

    always_comb begin
      num     = prod_r[j] + (61'(I) << 29);
      n       = 31'(num >> 30);
      q       = div_const(n, I);
      acc_nxt = (q > ONE_Q30) ? 31'd0 : ONE_Q30 - q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
        vb_r[j] <= 1'b0;
      end else begin
        va_r[j] <= v_i;
        vb_r[j] <= va_r[j];
      end
      prod_r[j] <= 61'(r_i) * 61'(acc_i);
      ra_r[j]   <= r_i;
      ka_r[j]   <= k_i;
      acc_r[j]  <= acc_nxt;
      rb_r[j]   <= ra_r[j];
      kb_r[j]   <= ka_r[j];
    end
  end

  // scale by 2^-k with rounding; large k underflows to zero
  logic [31:0] e_sum;
  logic [16:0] e_nxt;
  logic        ve_r;
  logic [16:0] e_r;

  always_comb begin
    e_sum = 32'(acc_r[EXP_TERMS-1]) + (32'd1 << (kb_r[EXP_TERMS-1] + 6'd13));
    if (kb_r[EXP_TERMS-1] >= 6'd18) begin
      e_nxt = '0;
    end else begin
      e_nxt = 17'(e_sum >> (kb_r[EXP_TERMS-1] + 6'd14));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vb_r[EXP_TERMS-1];
    end
    e_r <= e_nxt;
  end

  assign out_vld = ve_r;
  assign out_e   = e_r;

endmodule
`default_nettype wire

// ===== rtl/normal_cdf_erf_approx.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normal_cdf_erf_approx
// Standard normal CDF of a Q4.12 argument, returned as a Q1.16 probability.
// ----------------------------------------------------------------------------
//  channel | ports                            | handshake
//  --------+----------------------------------+------------------------------
//  input   | in_x_value[15:0] signed Q4.12    | start high, busy low
//  result  | out_probability[16:0] Q1.16      | out_valid strobe, one cycle
//
//  Fully pipelined: one item per cycle, every cycle. busy never rises.
//  Pipeline: two front stages (|x|/sqrt2, then p*z and z*z), 17 divider
//  stages for t, 5 Horner stages and one output stage; the exp path
//  (19 stages) runs beside the divider and is delayed to meet Horner.
//  rst_n (synchronous) clears all valid bits; data registers are not reset.
//  The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module normal_cdf_erf_approx (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_x_value,
  output logic                    out_valid,
  output logic [16:0]             out_probability
);
  import ncdf_pkg::*;

  assign busy = 1'b0;

  // stage 1: sign and z = |x| / sqrt(2)
  logic        accept;
  logic [16:0] ax;
  logic [32:0] z_full;
  logic        v1_r, neg1_r;
  logic [18:0] z_r;

  assign accept = start && !busy;

  always_comb begin
    ax     = in_x_value[15] ? 17'(-{in_x_value[15], in_x_value}) : 17'(in_x_value);
    z_full = 33'(ax) * 33'(INV_SQRT2_Q16) + 33'd2048;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    neg1_r <= in_x_value[15];
    z_r    <= z_full[30:12];
  end

  // stage 2: divisor d = 1 + p*z, and z squared
  logic [33:0] pz_full;
  logic [37:0] zz_full;
  ncdf_ctl_t   ctl2_r;
  logic [17:0] d_r;
  logic [21:0] w_r;

  always_comb begin
    pz_full = 34'(P_Q16) * 34'(z_r) + 34'd32768;
    zz_full = 38'(z_r) * 38'(z_r) + 38'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= '{vld: v1_r, neg: neg1_r};
    end
    d_r <= ONE_Q16 + 18'(pz_full[33:16]);
    w_r <= zz_full[37:16];
  end

  // t = 1/d, then the polynomial in t
  ncdf_ctl_t          rcp_ctl, hrn_ctl;
  logic [16:0]        t;
  logic signed [23:0] poly;

  ncdf_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (ctl2_r),
    .in_d    (d_r),
    .out_ctl (rcp_ctl),
    .out_t   (t)
  );

  ncdf_horner u_horner (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (rcp_ctl),
    .in_t     (t),
    .out_ctl  (hrn_ctl),
    .out_poly (poly)
  );

  // exp(-z*z), runs beside the divider
  logic        e_vld;
  logic [16:0] e;

  ncdf_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (ctl2_r.vld),
    .in_w    (w_r),
    .out_vld (e_vld),
    .out_e   (e)
  );

  // align exp with the Horner output
  logic        ev_dly_r [E_DELAY];
  logic [16:0] e_dly_r  [E_DELAY];

  for (genvar j = 0; j < E_DELAY; j++) begin : g_edly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ev_dly_r[j] <= 1'b0;
      end else begin
        ev_dly_r[j] <= (j == 0) ? e_vld : ev_dly_r[(j == 0) ? 0 : j-1];
      end
      e_dly_r[j] <= (j == 0) ? e : e_dly_r[(j == 0) ? 0 : j-1];
    end
  end

  // output stage: pe = poly*e, Phi = (1 +/- erf)/2 with clamp
  logic signed [41:0] pe_prod;
  logic signed [31:0] pe;
  logic signed [32:0] v_raw;
  logic [17:0]        v_clip;
  logic [18:0]        v_inc;
  logic               out_valid_r;
  logic [16:0]        out_prob_r;

  always_comb begin
    pe_prod = 42'(poly) * 42'($signed({1'b0, e_dly_r[E_DELAY-1]}));
    pe      = round_q16(48'(pe_prod));
    // 1 - erf = pe, so Phi*2 = pe for x < 0 and 2 - pe otherwise
    v_raw   = hrn_ctl.neg ? 33'(pe) : 33'sd131072 - 33'(pe);
    if (v_raw < 33'sd0) begin
      v_clip = '0;
    end else if (v_raw > 33'sd131072) begin
      v_clip = 18'd131072;
    end else begin
      v_clip = v_raw[17:0];
    end
    v_inc = 19'(v_clip) + 19'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hrn_ctl.vld && ev_dly_r[E_DELAY-1];
    end
    out_prob_r <= v_inc[17:1];
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;

endmodule
`default_nettype wire

// ===== rtl/ncdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncdf_checker
// Port-level checks on the normal CDF pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ncdf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [16:0] out_probability
);

  // never backpressures the sender
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy == 1'b0)
    else $error("busy raised");

  // every result comes from an item that the pipeline took
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 25))
    else $error("result without matching item");

  // probability stays within 0..1
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_probability <= 17'd65536))
    else $error("probability out of range");

endmodule

bind normal_cdf_erf_approx ncdf_checker u_ncdf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_probability (out_probability)
);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the normal CDF block: a bit-exact fixed-point
// predictor feeds a queue of expected probabilities, checked in order.
// ----------------------------------------------------------------------------

// Scoreboard: predicts Phi(x) for each accepted item, checks results in order.
class cdf_scoreboard;
  logic [16:0] pending_prob[$];
  int          mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Q16 rounding of a signed product, half away from zero
  static function longint rnd16(longint v);
    longint m;
    if (v < 0) begin
      m = -v;
      return -((m + 32768) >>> 16);
    end
    return (v + 32768) >>> 16;
  endfunction

  // exp(-w) in Q16 via 2^-k * exp(-f*ln2)
  static function longint exp_neg(longint w);
    longint u, k, f, r, acc, q, den;
    u = (w * 94548 + 32768) >>> 16;
    k = u >>> 16;
    f = u & 16'hFFFF;
    r = (f * 64'd744261118 + 32768) >>> 16;
    acc = 64'd1 << 30;
    for (int i = 8; i >= 1; i--) begin
      den = longint'(i) << 30;
      q = (r * acc + (longint'(i) << 29)) / den;
      acc = (q > (64'd1 << 30)) ? 0 : (64'd1 << 30) - q;
    end
    if (k + 14 > 62) return 0;
    return (acc + (64'd1 << (k + 13))) >>> (k + 14);
  endfunction

  static function logic [16:0] cdf_of(logic signed [15:0] x);
    logic   neg;
    longint ax, z, pz, d, t, acc, poly, w, e, pe, y, v;
    neg = x[15];
    ax = neg ? -longint'(x) : longint'(x);
    z = (ax * 46341 + 2048) >>> 12;
    pz = (21469 * z + 32768) >>> 16;
    d = 65536 + pz;
    t = ((64'd1 << 32) + d / 2) / d;
    acc = 69560;
    acc = rnd16(acc * t) - 95234;
    acc = rnd16(acc * t) + 93154;
    acc = rnd16(acc * t) - 18645;
    acc = rnd16(acc * t) + 16701;
    poly = rnd16(acc * t);
    w = (z * z + 32768) >>> 16;
    e = exp_neg(w);
    pe = rnd16(poly * e);
    y = 65536 - pe;
    v = neg ? 65536 - y : 65536 + y;
    if (v < 0) v = 0;
    if (v > 131072) v = 131072;
    return 17'((v + 1) >>> 1);
  endfunction

  function void note_item(logic signed [15:0] x);
    pending_prob.push_back(cdf_of(x));
  endfunction

  // returns 1 on a clean compare
  function bit check_result(logic [16:0] got, output logic [16:0] want,
                            output bit orphan);
    orphan = (pending_prob.size() == 0);
    want = 'x;
    if (orphan) return 0;
    want = pending_prob.pop_front();
    return got === want;
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;   // pipeline is 25 deep
  localparam int RANDOM_ITEMS   = 1800;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_x_value;
  logic               out_valid;
  logic [16:0]        out_probability;

  cdf_scoreboard sb;
  int            fail_count;
  int            idle_cycles;

  normal_cdf_erf_approx dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_x_value      (in_x_value),
    .out_valid       (out_valid),
    .out_probability (out_probability)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report(string what, logic [16:0] got, logic [16:0] want);
    $display("mismatch: %s got=%0d want=%0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Result side: the block strobes each result for one cycle, no stall possible.
  always @(posedge clk) begin
    logic [16:0] want;
    bit          orphan;
    if (rst_n && out_valid) begin
      if (!sb.check_result(out_probability, want, orphan))
        report(orphan ? "unexpected result" : "probability", out_probability, want);
    end
  end

  // Watchdog: counts cycles where neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Send one item after a gap; start stays high across back-to-back items.
  task automatic send_item(logic signed [15:0] x, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_x_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(x);
  endtask

  function automatic int draw_gap();
    // no gap one time in four, otherwise 0..14
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    logic signed [15:0] directed[$];
    logic signed [15:0] x;
    int                 sel;
    int                 drain;

    sb          = new();
    fail_count  = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_x_value  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, zero (taken as positive), tiny values, the tail where the
    // exp term vanishes and where the clamp keeps the result in range.
    directed = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, -16'sd1,
                 16'sd4096, -16'sd4096, 16'sd8192, -16'sd8192,
                 16'sd12288, -16'sd12288, 16'sd16384, -16'sd16384,
                 16'sd24576, -16'sd24576, 16'sd2048, -16'sd2048,
                 16'sh5555, 16'shAAAA, 16'sd32000, -16'sd32000,
                 16'sd100, -16'sd100};
    foreach (directed[i]) send_item(directed[i], (i % 3 == 0) ? 0 : $urandom_range(0, 14));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0:       x = 16'($urandom);                          // full range
        1:       x = 16'($signed($urandom_range(0, 16383)) - 8192); // |x| <= 2
        2:       x = 16'($signed($urandom_range(0, 32767)) - 16384); // |x| <= 4
        default: x = 16'($signed($urandom_range(0, 511)) - 256);
      endcase
      send_item(x, draw_gap());
    end
    start <= 1'b0;

    drain = 0;
    while (sb.pending_prob.size() != 0 && drain < 10 * DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending_prob.size() != 0) begin
      $display("mismatch: %0d results never arrived", sb.pending_prob.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
